[src/bssi_pkg.sv]
// Package for the brush stroke stamp interpolator.
// Holds event and register codes, the configuration struct and back-end states.
package bssi_pkg;

    localparam int CoordBitsDef = 12;
    localparam int MaxStepsDef  = 64;
    localparam int ByteBits     = 8;
    localparam int CfgIdxBits   = 3;

    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_MOVE    = 2'd2,
        FUNC_TOOL    = 2'd3
    } t_func;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_SIZE  = 3'd0,
        REG_RED   = 3'd1,
        REG_GREEN = 3'd2,
        REG_BLUE  = 3'd3,
        REG_ALPHA = 3'd4
    } t_reg;

    typedef struct packed {
        logic [ByteBits-1:0] size;
        logic [ByteBits-1:0] red;
        logic [ByteBits-1:0] green;
        logic [ByteBits-1:0] blue;
        logic [ByteBits-1:0] alpha;
    } t_cfg;

    // command kinds passed from front to back
    localparam logic CMD_SINGLE = 1'b0;
    localparam logic CMD_INTERP = 1'b1;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SQX,
        BS_SQY,
        BS_STEPS,
        BS_DIV,
        BS_FIX,
        BS_EMIT
    } t_bstate;

endpackage

[src/brush_stroke_stamp_interpolator_unit.sv]
// Top level of the brush stroke stamp interpolator: config registers,
// front end, command queue, back end. Depends on bssi_pkg and its submodules.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------------
//  event in  | push / full                | i_func i_button i_pos_x i_pos_y
//  stamp out | empty / pop                | o_stamp_x o_stamp_y o_stamp_rgba o_last_of_run
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// Events are taken while not full; a two-entry command queue feeds the back end.
// A move squares the distance, searches the step count (up to MAX_STEPS), divides,
// then emits one stamp per cycle while pop keeps up; press/release emit one stamp.
// Synchronous active-low reset clears stroke state, queue and output valid.
// full rises only when both queue entries wait behind a busy back end.
module brush_stroke_stamp_interpolator_unit #(
    parameter int COORD_BITS = bssi_pkg::CoordBitsDef,
    parameter int MAX_STEPS  = bssi_pkg::MaxStepsDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_func,
    input  logic [2:0]                        i_button,
    input  logic [COORD_BITS-1:0]             i_pos_x,
    input  logic [COORD_BITS-1:0]             i_pos_y,
    output logic                              empty,
    input  logic                              pop,
    output logic [COORD_BITS-1:0]             o_stamp_x,
    output logic [COORD_BITS-1:0]             o_stamp_y,
    output logic [31:0]                       o_stamp_rgba,
    output logic                              o_last_of_run,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bssi_pkg::CfgIdxBits-1:0]   i_cfg_index,
    input  logic [bssi_pkg::ByteBits-1:0]     i_cfg_data
);
    localparam int CmdW = 4 * COORD_BITS + 1;

    bssi_pkg::t_cfg  r_cfg;
    logic            q_push, q_pop, q_full, q_empty;
    logic [CmdW-1:0] q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size  <= 8'd8;
            r_cfg.red   <= 8'd0;
            r_cfg.green <= 8'd0;
            r_cfg.blue  <= 8'd0;
            r_cfg.alpha <= 8'd255;
        end else if (i_cfg_valid) begin
            case (bssi_pkg::t_reg'(i_cfg_index))
                bssi_pkg::REG_SIZE:  r_cfg.size  <= i_cfg_data;
                bssi_pkg::REG_RED:   r_cfg.red   <= i_cfg_data;
                bssi_pkg::REG_GREEN: r_cfg.green <= i_cfg_data;
                bssi_pkg::REG_BLUE:  r_cfg.blue  <= i_cfg_data;
                bssi_pkg::REG_ALPHA: r_cfg.alpha <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bssi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_func   (i_func),
        .i_button (i_button),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    bssi_cmdq #(.WIDTH(CmdW)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    bssi_back #(.COORD_BITS(COORD_BITS), .MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_cfg         (r_cfg),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_stamp_x     (o_stamp_x),
        .o_stamp_y     (o_stamp_y),
        .o_stamp_rgba  (o_stamp_rgba),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[src/bssi_front.sv]
// Front end: accepts pointer events, keeps the stroke state, issues commands.
// Depends on bssi_pkg.
module bssi_front #(
    parameter int COORD_BITS = bssi_pkg::CoordBitsDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [1:0]                i_func,
    input  logic [2:0]                i_button,
    input  logic [COORD_BITS-1:0]     i_pos_x,
    input  logic [COORD_BITS-1:0]     i_pos_y,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output logic [4*COORD_BITS:0]     o_q_data
);
    logic                  r_painting, n_painting;
    logic                  r_have, n_have;
    logic [COORD_BITS-1:0] r_lx, n_lx, r_ly, n_ly;
    logic                  accept;

    assign accept = i_push && !i_q_full;

    always_comb begin
        n_painting = r_painting;
        n_have     = r_have;
        n_lx       = r_lx;
        n_ly       = r_ly;
        o_q_push   = 1'b0;
        o_q_data   = {bssi_pkg::CMD_SINGLE, i_pos_x, i_pos_y, i_pos_x, i_pos_y};
        if (accept) begin
            case (bssi_pkg::t_func'(i_func))
                bssi_pkg::FUNC_PRESS: begin
                    if (i_button == 3'd0) begin
                        n_painting = 1'b1;
                        n_have     = 1'b1;
                        n_lx       = i_pos_x;
                        n_ly       = i_pos_y;
                        o_q_push   = 1'b1;
                    end
                end
                bssi_pkg::FUNC_RELEASE: begin
                    if (i_button == 3'd0) begin
                        o_q_push   = r_painting;
                        n_painting = 1'b0;
                        n_have     = 1'b0;
                        n_lx       = '0;
                        n_ly       = '0;
                    end
                end
                bssi_pkg::FUNC_MOVE: begin
                    if (r_painting) begin
                        o_q_push = 1'b1;
                        // without a last point the move starts from itself
                        o_q_data = {bssi_pkg::CMD_INTERP, i_pos_x, i_pos_y,
                                    r_have ? r_lx : i_pos_x, r_have ? r_ly : i_pos_y};
                        n_have   = 1'b1;
                        n_lx     = i_pos_x;
                        n_ly     = i_pos_y;
                    end
                end
                default: begin
                    n_painting = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_painting <= 1'b0;
            r_have     <= 1'b0;
            r_lx       <= '0;
            r_ly       <= '0;
        end else begin
            r_painting <= n_painting;
            r_have     <= n_have;
            r_lx       <= n_lx;
            r_ly       <= n_ly;
        end
    end

endmodule

[src/bssi_cmdq.sv]
// Two-entry command queue between front and back end.
// Depends on nothing but its width parameter.
module bssi_cmdq #(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp)) else $error("queue pointers disagree");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> o_full) else $error("full queue lost an entry");

endmodule

[src/bssi_back.sv]
// Back end: step count search, per-axis divider and stamp emission.
// Depends on bssi_pkg.
module bssi_back #(
    parameter int COORD_BITS = bssi_pkg::CoordBitsDef,
    parameter int MAX_STEPS  = bssi_pkg::MaxStepsDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  logic [4*COORD_BITS:0]   i_q_data,
    output logic                    o_q_pop,
    input  bssi_pkg::t_cfg          i_cfg,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic [COORD_BITS-1:0]   o_stamp_x,
    output logic [COORD_BITS-1:0]   o_stamp_y,
    output logic [31:0]             o_stamp_rgba,
    output logic                    o_last_of_run
);
    localparam int CB  = COORD_BITS;
    localparam int SW  = $clog2(MAX_STEPS + 1);
    localparam int RW  = SW + 2;
    localparam int PW  = SW + bssi_pkg::ByteBits;
    localparam int DW  = 2 * CB + 1;
    localparam int CW  = (2 * PW > DW + 4) ? 2 * PW : DW + 4;
    localparam int IW  = $clog2(CB + 1);

    bssi_pkg::t_bstate r_state, n_state;

    logic                  cmd_kind;
    logic [CB-1:0]         cmd_x, cmd_y, cmd_lx, cmd_ly;

    logic [CB-1:0]         r_x, r_y, r_lx, r_ly;
    logic [DW-1:0]         r_d2;
    logic [SW-1:0]         r_k, r_i;
    logic [PW-1:0]         r_s;
    logic [CB-1:0]         r_qx, r_qy;
    logic [SW-1:0]         r_dvx, r_dvy;
    logic                  r_nx, r_ny;
    logic [IW-1:0]         r_it;
    logic signed [CB:0]    r_accx, r_accy, r_qdx, r_qdy;
    logic [RW-1:0]         r_remx, r_remy, r_rdx, r_rdy;
    logic                  r_ovalid;
    logic [CB-1:0]         r_ox, r_oy;
    logic                  r_olast;

    logic signed [CB:0]    dx, dy;
    logic [CB-1:0]         ax, ay;
    logic [CW-1:0]         sq, lim;
    logic [SW:0]           tx, ty;
    logic                  bx, by;
    logic [RW-1:0]         two_k, srx, sry;
    logic signed [CB:0]    sax, say;
    logic [CB:0]           px, py;
    logic                  out_free;

    assign {cmd_kind, cmd_x, cmd_y, cmd_lx, cmd_ly} = i_q_data;
    assign out_free = !r_ovalid || i_pop;

    assign dx = $signed({1'b0, r_x}) - $signed({1'b0, r_lx});
    assign dy = $signed({1'b0, r_y}) - $signed({1'b0, r_ly});
    assign ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    assign ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];

    assign sq  = CW'(r_s) * CW'(r_s);
    assign lim = CW'({r_d2, 4'b0000});

    // one restoring divide step per axis
    assign tx = {r_dvx, r_qx[CB-1]};
    assign ty = {r_dvy, r_qy[CB-1]};
    assign bx = (tx >= {1'b0, r_k});
    assign by = (ty >= {1'b0, r_k});

    // running quotient and remainder of (2*d*i + k) / (2*k)
    assign two_k = {1'b0, r_k, 1'b0};
    always_comb begin
        srx = r_remx + r_rdx;
        sry = r_remy + r_rdy;
        sax = r_accx + r_qdx;
        say = r_accy + r_qdy;
        if (srx >= two_k) begin
            srx = srx - two_k;
            sax = sax + (CB+1)'(1);
        end
        if (sry >= two_k) begin
            sry = sry - two_k;
            say = say + (CB+1)'(1);
        end
        px = $unsigned($signed({1'b0, r_lx}) + sax);
        py = $unsigned($signed({1'b0, r_ly}) + say);
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            bssi_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = (cmd_kind == bssi_pkg::CMD_INTERP) ? bssi_pkg::BS_SQX
                                                                 : bssi_pkg::BS_EMIT;
                end
            end
            bssi_pkg::BS_SQX:   n_state = bssi_pkg::BS_SQY;
            bssi_pkg::BS_SQY:   n_state = bssi_pkg::BS_STEPS;
            bssi_pkg::BS_STEPS: begin
                if (!(r_k < SW'(MAX_STEPS) && sq <= lim)) n_state = bssi_pkg::BS_DIV;
            end
            bssi_pkg::BS_DIV: begin
                if (r_it == IW'(CB - 1)) n_state = bssi_pkg::BS_FIX;
            end
            bssi_pkg::BS_FIX:   n_state = bssi_pkg::BS_EMIT;
            bssi_pkg::BS_EMIT: begin
                if (out_free && r_i == r_k) n_state = bssi_pkg::BS_IDLE;
            end
            default:            n_state = bssi_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bssi_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bssi_pkg::BS_IDLE: begin
                r_x    <= cmd_x;
                r_y    <= cmd_y;
                r_lx   <= (cmd_kind == bssi_pkg::CMD_INTERP) ? cmd_lx : cmd_x;
                r_ly   <= (cmd_kind == bssi_pkg::CMD_INTERP) ? cmd_ly : cmd_y;
                r_k    <= SW'(1);
                r_i    <= SW'(1);
                r_accx <= '0;
                r_accy <= '0;
                r_qdx  <= '0;
                r_qdy  <= '0;
                r_rdx  <= '0;
                r_rdy  <= '0;
                r_remx <= RW'(1);
                r_remy <= RW'(1);
            end
            bssi_pkg::BS_SQX: begin
                r_qx <= ax;
                r_nx <= dx[CB];
                r_d2 <= DW'(ax) * DW'(ax);
            end
            bssi_pkg::BS_SQY: begin
                r_qy  <= ay;
                r_ny  <= dy[CB];
                r_d2  <= r_d2 + DW'(ay) * DW'(ay);
                r_s   <= PW'({i_cfg.size, 1'b0});
            end
            bssi_pkg::BS_STEPS: begin
                r_dvx <= '0;
                r_dvy <= '0;
                r_it  <= '0;
                if (r_k < SW'(MAX_STEPS) && sq <= lim) begin
                    r_k <= r_k + SW'(1);
                    r_s <= r_s + PW'(i_cfg.size);
                end
            end
            bssi_pkg::BS_DIV: begin
                r_dvx <= bx ? SW'(tx - {1'b0, r_k}) : tx[SW-1:0];
                r_dvy <= by ? SW'(ty - {1'b0, r_k}) : ty[SW-1:0];
                r_qx  <= {r_qx[CB-2:0], bx};
                r_qy  <= {r_qy[CB-2:0], by};
                r_it  <= r_it + IW'(1);
            end
            bssi_pkg::BS_FIX: begin
                // turn truncated quotient of |d| into floor division of d
                if (r_nx && r_dvx != '0) begin
                    r_qdx <= -$signed({1'b0, r_qx}) - (CB+1)'(1);
                    r_rdx <= {1'b0, r_k - r_dvx, 1'b0};
                end else begin
                    r_qdx <= r_nx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
                    r_rdx <= {1'b0, r_dvx, 1'b0};
                end
                if (r_ny && r_dvy != '0) begin
                    r_qdy <= -$signed({1'b0, r_qy}) - (CB+1)'(1);
                    r_rdy <= {1'b0, r_k - r_dvy, 1'b0};
                end else begin
                    r_qdy <= r_ny ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
                    r_rdy <= {1'b0, r_dvy, 1'b0};
                end
                r_accx <= '0;
                r_accy <= '0;
                r_remx <= RW'(r_k);
                r_remy <= RW'(r_k);
                r_i    <= SW'(1);
            end
            bssi_pkg::BS_EMIT: begin
                if (out_free) begin
                    r_accx <= sax;
                    r_accy <= say;
                    r_remx <= srx;
                    r_remy <= sry;
                    r_i    <= r_i + SW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == bssi_pkg::BS_EMIT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bssi_pkg::BS_EMIT && out_free) begin
            r_ox    <= px[CB-1:0];
            r_oy    <= py[CB-1:0];
            r_olast <= (r_i == r_k);
        end
    end

    assign o_empty       = !r_ovalid;
    assign o_stamp_x     = r_ox;
    assign o_stamp_y     = r_oy;
    assign o_last_of_run = r_olast;
    assign o_stamp_rgba  = {i_cfg.red, i_cfg.green, i_cfg.blue, i_cfg.alpha};

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bssi_pkg::BS_DIV) |-> (r_k != '0)) else $error("zero step count");
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bssi_pkg::BS_EMIT) |-> (r_i != '0 && r_i <= r_k))
        else $error("stamp index out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == bssi_pkg::BS_IDLE && !i_q_empty))
        else $error("command taken while busy");

endmodule

[bench/brush_stroke_stamp_interpolator_unit_test.sv]
// Testbench for brush_stroke_stamp_interpolator_unit: drives pointer events and
// register writes, predicts every stamp and checks it. Depends on bssi_pkg.
`timescale 1ns / 1ps

module brush_stroke_stamp_interpolator_unit_test;

    localparam int CW = bssi_pkg::CoordBitsDef;
    localparam int MAX_ST = bssi_pkg::MaxStepsDef;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [31:0]   rgba;
        logic          last;
    } t_stamp;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            push = 1'b0;
    logic            full;
    logic [1:0]      i_func = '0;
    logic [2:0]      i_button = '0;
    logic [CW-1:0]   i_pos_x = '0;
    logic [CW-1:0]   i_pos_y = '0;
    logic            empty;
    logic            pop = 1'b0;
    logic [CW-1:0]   o_stamp_x;
    logic [CW-1:0]   o_stamp_y;
    logic [31:0]     o_stamp_rgba;
    logic            o_last_of_run;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [bssi_pkg::CfgIdxBits-1:0] i_cfg_index = '0;
    logic [bssi_pkg::ByteBits-1:0]   i_cfg_data = '0;

    brush_stroke_stamp_interpolator_unit u_top (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    bssi_pkg::t_cfg cfg_shadow;
    logic          pr_painting;
    logic          pr_have_last;
    logic [CW-1:0] pr_last_x;
    logic [CW-1:0] pr_last_y;
    t_stamp        stamps_due[$];

    int  errors = 0;
    int  idle_cycles = 0;
    int  send_gap_pct = 0;
    int  pop_gap_pct = 0;

    function automatic logic [CW-1:0] lerp_round(logic [CW-1:0] base, longint d,
                                                  longint i, longint n);
        longint num;
        num = 2 * (longint'(base) * n + d * i) + n;
        if (num < 0) return '0;
        return CW'(num / (2 * n));
    endfunction

    function automatic void predict_stamps(bssi_pkg::t_func f, logic [2:0] btn,
                                            logic [CW-1:0] px, logic [CW-1:0] py);
        longint dx, dy, dist16, sz, n;
        logic [31:0] rgba;
        rgba = {cfg_shadow.red, cfg_shadow.green, cfg_shadow.blue, cfg_shadow.alpha};
        case (f)
            bssi_pkg::FUNC_PRESS: begin
                if (btn != 3'd0) return;
                pr_painting = 1'b1;
                pr_have_last = 1'b1;
                pr_last_x = px;
                pr_last_y = py;
                stamps_due.push_back({px, py, rgba, 1'b1});
            end
            bssi_pkg::FUNC_RELEASE: begin
                if (btn != 3'd0) return;
                if (pr_painting) stamps_due.push_back({px, py, rgba, 1'b1});
                pr_painting = 1'b0;
                pr_have_last = 1'b0;
                pr_last_x = '0;
                pr_last_y = '0;
            end
            bssi_pkg::FUNC_MOVE: begin
                if (!pr_painting) return;
                if (!pr_have_last) begin
                    pr_last_x = px;
                    pr_last_y = py;
                    pr_have_last = 1'b1;
                end
                dx = longint'(px) - longint'(pr_last_x);
                dy = longint'(py) - longint'(pr_last_y);
                dist16 = 16 * (dx * dx + dy * dy);
                sz = longint'(cfg_shadow.size);
                n = 1;
                while (n < MAX_ST && ((n + 1) * sz) * ((n + 1) * sz) <= dist16) n++;
                for (longint i = 1; i <= n; i++)
                    stamps_due.push_back({lerp_round(pr_last_x, dx, i, n),
                                          lerp_round(pr_last_y, dy, i, n), rgba, i == n});
                pr_last_x = px;
                pr_last_y = py;
            end
            default: pr_painting = 1'b0;
        endcase
    endfunction

    // result side: random stall, compare each accepted stamp
    always @(posedge i_clk) begin
        t_stamp want;
        if (i_rst_n && pop && !empty) begin
            if (stamps_due.size() == 0) begin
                $error("unexpected stamp x=%0d y=%0d", o_stamp_x, o_stamp_y);
                errors++;
            end else begin
                want = stamps_due.pop_front();
                if (o_stamp_x !== want.x) begin
                    $error("stamp_x expected %0d got %0d", want.x, o_stamp_x);
                    errors++;
                end
                if (o_stamp_y !== want.y) begin
                    $error("stamp_y expected %0d got %0d", want.y, o_stamp_y);
                    errors++;
                end
                if (o_stamp_rgba !== want.rgba) begin
                    $error("stamp_rgba expected %h got %h", want.rgba, o_stamp_rgba);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run expected %0d got %0d", want.last, o_last_of_run);
                    errors++;
                end
            end
        end
        pop <= ($urandom_range(99) >= pop_gap_pct);
    end

    // watchdog on cycles with no accepted item or stamp
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("brush_stroke_stamp_interpolator_unit_test failed");
            $finish;
        end
    end

    // push stays high from one item to the next unless the sender idles
    task automatic send_event(bssi_pkg::t_func f, logic [2:0] btn, logic [CW-1:0] px,
                              logic [CW-1:0] py);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_func <= f;
        i_button <= btn;
        i_pos_x <= px;
        i_pos_y <= py;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_stamps(f, btn, px, py);
    endtask

    task automatic drain_stamps();
        push <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (stamps_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // valid stays high from one write to the next; the next event or drain drops it
    task automatic write_reg(bssi_pkg::t_reg idx, logic [7:0] val);
        push <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            bssi_pkg::REG_SIZE:  cfg_shadow.size = val;
            bssi_pkg::REG_RED:   cfg_shadow.red = val;
            bssi_pkg::REG_GREEN: cfg_shadow.green = val;
            bssi_pkg::REG_BLUE:  cfg_shadow.blue = val;
            bssi_pkg::REG_ALPHA: cfg_shadow.alpha = val;
            default: ;
        endcase
    endtask

    task automatic set_colors(logic [31:0] rgba);
        write_reg(bssi_pkg::REG_RED, rgba[31:24]);
        write_reg(bssi_pkg::REG_GREEN, rgba[23:16]);
        write_reg(bssi_pkg::REG_BLUE, rgba[15:8]);
        write_reg(bssi_pkg::REG_ALPHA, rgba[7:0]);
    endtask

    task automatic test_directed();
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd10, 12'd10);        // move while idle
        send_event(bssi_pkg::FUNC_RELEASE, 3'd0, 12'd5, 12'd5);       // release while idle
        send_event(bssi_pkg::FUNC_PRESS, 3'd7, 12'd1, 12'd1);         // non-left press
        send_event(bssi_pkg::FUNC_PRESS, 3'd0, 12'd0, 12'd0);
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd4095, 12'd4095);    // long move saturates
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd0, 12'd4095);
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd0, 12'd4095);       // zero distance
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd3, 12'd4094);
        send_event(bssi_pkg::FUNC_RELEASE, 3'd1, 12'd0, 12'd0);       // non-left release
        send_event(bssi_pkg::FUNC_PRESS, 3'd0, 12'd2048, 12'd1024);   // press while painting
        send_event(bssi_pkg::FUNC_RELEASE, 3'd0, 12'd4095, 12'd0);
        send_event(bssi_pkg::FUNC_PRESS, 3'd0, 12'd100, 12'd100);
        send_event(bssi_pkg::FUNC_TOOL, 3'd5, 12'd7, 12'd7);          // tool clears painting
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd200, 12'd200);
        send_event(bssi_pkg::FUNC_PRESS, 3'd0, 12'd300, 12'd300);
        send_event(bssi_pkg::FUNC_RELEASE, 3'd2, 12'd0, 12'd0);
        send_event(bssi_pkg::FUNC_RELEASE, 3'd0, 12'd310, 12'd310);
        drain_stamps();
        write_reg(bssi_pkg::REG_SIZE, 8'd0);                          // size zero saturates
        set_colors(32'hFFFF_FFFF);
        send_event(bssi_pkg::FUNC_PRESS, 3'd0, 12'd50, 12'd60);
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd51, 12'd60);
        drain_stamps();
        write_reg(bssi_pkg::REG_SIZE, 8'd255);
        set_colors(32'h00A5_5A00);
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd4000, 12'd60);
        send_event(bssi_pkg::FUNC_MOVE, 3'd0, 12'd4000, 12'd70);
        send_event(bssi_pkg::FUNC_RELEASE, 3'd0, 12'd1, 12'd2);
        drain_stamps();
    endtask

    task automatic test_random(int count);
        int f;
        logic [CW-1:0] x, y;
        for (int k = 0; k < count; k++) begin
            f = $urandom_range(99);
            // mostly short strokes: press, nearby moves, release
            x = CW'($urandom);
            y = CW'($urandom);
            if (f < 15) send_event(bssi_pkg::FUNC_PRESS,
                                   ($urandom_range(9) == 0) ? 3'($urandom) : 3'd0, x, y);
            else if (f < 25) send_event(bssi_pkg::FUNC_RELEASE,
                                        ($urandom_range(9) == 0) ? 3'($urandom) : 3'd0, x, y);
            else if (f < 30) send_event(bssi_pkg::FUNC_TOOL, 3'($urandom), x, y);
            else if (f < 40) send_event(bssi_pkg::FUNC_MOVE, 3'($urandom), x, y);
            else send_event(bssi_pkg::FUNC_MOVE, 3'($urandom),
                            pr_last_x + CW'($urandom_range(120)) - CW'(60),
                            pr_last_y + CW'($urandom_range(120)) - CW'(60));
        end
        drain_stamps();
    endtask

    task automatic test_phase(int sg, int pg, logic [7:0] sz);
        send_gap_pct = sg;
        pop_gap_pct = pg;
        write_reg(bssi_pkg::REG_SIZE, sz);
        set_colors($urandom);
        test_random(26);
    endtask

    initial begin
        cfg_shadow = '{size: 8'd8, red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};
        pr_painting = 1'b0;
        pr_have_last = 1'b0;
        pr_last_x = '0;
        pr_last_y = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_phase(37, 57, 8'd1);
        test_phase(57, 37, 8'($urandom_range(2, 40)));
        test_phase(0, 0, 8'd8);
        if (stamps_due.size() != 0) begin
            $error("%0d stamps never arrived", stamps_due.size());
            errors++;
        end
        if (errors == 0)
            $display("brush_stroke_stamp_interpolator_unit_test passed");
        else
            $display("brush_stroke_stamp_interpolator_unit_test failed");
        $finish;
    end

endmodule
